// ===== design/qast_pkg.sv =====
// ----------------------------------------------------------------------------
// qast_pkg
// Shared types and constants for the quote-aware shell tokenizer.
// ----------------------------------------------------------------------------
package qast_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int MAX_RESULTS = 3;

   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_PIPE   = 8'h7C;
   localparam logic [7:0] CHAR_GT     = 8'h3E;
   localparam logic [7:0] CHAR_LT     = 8'h3C;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;

   typedef enum logic [1:0] {
      QS_NONE   = 2'd0,
      QS_SINGLE = 2'd1,
      QS_DOUBLE = 2'd2
   } quote_type;

   typedef enum logic [1:0] {
      CLS_SPACE = 2'd0,
      CLS_WORD  = 2'd1,
      CLS_OP    = 2'd2
   } class_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       ends_token;
      logic       operator_token;
      logic       line_done;
      logic       unbalanced_quote;
   } result_type;

   // All results caused by one input item; count is never zero in the queue.
   typedef struct packed {
      result_type [MAX_RESULTS-1:0] res;
      logic [1:0]                   count;
   } bundle_type;

endpackage

// ===== design/quote_aware_shell_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// quote_aware_shell_tokenizer_core
// Splits a command line, one byte per item, into word and operator tokens.
//
// Channel   Direction  Handshake      Payload
// req       in         push / full    ch, end_of_line
// rsp       out        pop / empty    out_char, ends_token, operator_token,
//                                     line_done, unbalanced_quote, last
//
// One input byte is taken per cycle while the bundle queue has room.
// Each result is presented on its own, one at a time, so an item that
// causes k results presents them in turn (k is at most three).
// A result reaches the outputs once its bundle is at the head of the queue.
// Reset clears the quote state, the held byte and the queue.
// ----------------------------------------------------------------------------
module quote_aware_shell_tokenizer_core #(
   parameter int QUEUE_DEPTH = qast_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_ch,
   input  logic       req_end_of_line,
   input  logic       push,
   output logic       full,
   output logic [7:0] rsp_out_char,
   output logic       rsp_ends_token,
   output logic       rsp_operator_token,
   output logic       rsp_line_done,
   output logic       rsp_unbalanced_quote,
   output logic       rsp_last,
   output logic       empty,
   input  logic       pop
);
   import qast_pkg::*;

   logic       accept;
   logic       bundle_push;
   bundle_type bundle;
   bundle_type head;
   logic       q_empty;
   logic       q_full;
   logic       head_release;

   assign full = q_full;
   assign accept = push && !q_full;

   qast_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .ch          (req_ch),
      .end_of_line (req_end_of_line),
      .bundle_push (bundle_push),
      .bundle      (bundle)
   );

   qast_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (bundle_push),
      .wr_data (bundle),
      .rd_en   (head_release),
      .rd_data (head),
      .q_empty (q_empty),
      .q_full  (q_full)
   );

   qast_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .head_valid       (!q_empty),
      .pop              (pop),
      .head_release     (head_release),
      .empty            (empty),
      .out_char         (rsp_out_char),
      .ends_token       (rsp_ends_token),
      .operator_token   (rsp_operator_token),
      .line_done        (rsp_line_done),
      .unbalanced_quote (rsp_unbalanced_quote),
      .last             (rsp_last)
   );

endmodule

// ===== design/qast_front.sv =====
// ----------------------------------------------------------------------------
// qast_front
// Classifies each byte, tracks the quote state and the held byte, and builds
// the bundle of results that the byte causes.
// ----------------------------------------------------------------------------
module qast_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          ch,
   input  logic                end_of_line,
   output logic                bundle_push,
   output qast_pkg::bundle_type bundle
);
   import qast_pkg::*;

   quote_type  quote_ff, quote_in;
   logic [7:0] held_byte_ff, held_byte_in;
   logic       held_valid_ff, held_valid_in;
   logic       token_open_ff, token_open_in;

   quote_type  qs;
   class_type  cls;
   logic [1:0] n;
   logic       consumed;
   logic       is_op;

   always_comb begin
      is_op = (ch == CHAR_PIPE) || (ch == CHAR_LT) || (ch == CHAR_GT);
      qs = quote_ff;
      cls = CLS_WORD;
      unique case (quote_ff)
         QS_SINGLE: begin
            if (ch == CHAR_SQUOTE) qs = QS_NONE;
         end
         QS_DOUBLE: begin
            if (ch == CHAR_DQUOTE) qs = QS_NONE;
         end
         default: begin
            if (ch == CHAR_SPACE) begin
               cls = CLS_SPACE;
            end else if (is_op) begin
               cls = CLS_OP;
            end else if (ch == CHAR_SQUOTE) begin
               qs = QS_SINGLE;
            end else if (ch == CHAR_DQUOTE) begin
               qs = QS_DOUBLE;
            end
         end
      endcase

      n = 2'd0;
      consumed = 1'b0;
      bundle = '0;
      held_byte_in = held_byte_ff;
      held_valid_in = held_valid_ff;
      token_open_in = token_open_ff;
      quote_in = qs;

      if (held_valid_ff) begin
         if (token_open_ff) begin
            if (cls == CLS_WORD) begin
               bundle.res[n] = '{held_byte_ff, 1'b0, 1'b0, 1'b0, 1'b0};
            end else begin
               bundle.res[n] = '{held_byte_ff, 1'b1, 1'b0, 1'b0, 1'b0};
               token_open_in = 1'b0;
            end
            n = n + 2'd1;
         end else if ((held_byte_ff == CHAR_LT || held_byte_ff == CHAR_GT) &&
                      cls == CLS_OP && ch == held_byte_ff) begin
            bundle.res[n] = '{held_byte_ff, 1'b0, 1'b1, 1'b0, 1'b0};
            n = n + 2'd1;
            bundle.res[n] = '{ch, 1'b1, 1'b1, 1'b0, 1'b0};
            n = n + 2'd1;
            consumed = 1'b1;
         end else begin
            bundle.res[n] = '{held_byte_ff, 1'b1, 1'b1, 1'b0, 1'b0};
            n = n + 2'd1;
         end
         held_valid_in = 1'b0;
         held_byte_in = 8'h00;
      end

      if (!consumed) begin
         if (cls == CLS_WORD) begin
            held_byte_in = ch;
            held_valid_in = 1'b1;
            token_open_in = 1'b1;
         end else if (cls == CLS_OP) begin
            held_byte_in = ch;
            held_valid_in = 1'b1;
            token_open_in = 1'b0;
         end
      end

      if (end_of_line) begin
         if (held_valid_in) begin
            bundle.res[n] = '{held_byte_in, 1'b1, !token_open_in, 1'b0, 1'b0};
            n = n + 2'd1;
         end
         bundle.res[n] = '{8'h00, 1'b0, 1'b0, 1'b1, qs != QS_NONE};
         n = n + 2'd1;
         quote_in = QS_NONE;
         held_byte_in = 8'h00;
         held_valid_in = 1'b0;
         token_open_in = 1'b0;
      end

      bundle.count = n;
      bundle_push = accept && (n != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quote_ff <= QS_NONE;
         held_byte_ff <= 8'h00;
         held_valid_ff <= 1'b0;
         token_open_ff <= 1'b0;
      end else if (accept) begin
         quote_ff <= quote_in;
         held_byte_ff <= held_byte_in;
         held_valid_ff <= held_valid_in;
         token_open_ff <= token_open_in;
      end
   end

endmodule

// ===== design/qast_queue.sv =====
// ----------------------------------------------------------------------------
// qast_queue
// Short queue of result bundles between the front and back parts.
// ----------------------------------------------------------------------------
module qast_queue #(
   parameter int DEPTH = qast_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  qast_pkg::bundle_type wr_data,
   input  logic                rd_en,
   output qast_pkg::bundle_type rd_data,
   output logic                q_empty,
   output logic                q_full
);
   import qast_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   bundle_type        mem_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_wr, do_rd;

   assign q_empty = (count_ff == '0);
   assign q_full  = (count_ff == CW'(DEPTH));
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== design/qast_back.sv =====
// ----------------------------------------------------------------------------
// qast_back
// Walks through the results of the bundle at the head of the queue and
// presents them one at a time.
// ----------------------------------------------------------------------------
module qast_back (
   input  logic                clock,
   input  logic                reset,
   input  qast_pkg::bundle_type head,
   input  logic                head_valid,
   input  logic                pop,
   output logic                head_release,
   output logic                empty,
   output logic [7:0]          out_char,
   output logic                ends_token,
   output logic                operator_token,
   output logic                line_done,
   output logic                unbalanced_quote,
   output logic                last
);
   import qast_pkg::*;

   logic [1:0] idx_ff, idx_in;
   result_type cur;

   always_comb begin
      cur = head.res[idx_ff];
      out_char = cur.out_char;
      ends_token = cur.ends_token;
      operator_token = cur.operator_token;
      line_done = cur.line_done;
      unbalanced_quote = cur.unbalanced_quote;
      last = (idx_ff == head.count - 2'd1);
      empty = !head_valid;
      head_release = pop && head_valid && last;
      idx_in = idx_ff;
      if (pop && head_valid) begin
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// ===== design/qast_checker.sv =====
// ----------------------------------------------------------------------------
// qast_checker
// Port-level checks on the tokenizer's result stream.
// ----------------------------------------------------------------------------
module qast_checker (
   input logic       clock,
   input logic       reset,
   input logic       full,
   input logic       empty,
   input logic       pop,
   input logic [7:0] rsp_out_char,
   input logic       rsp_ends_token,
   input logic       rsp_operator_token,
   input logic       rsp_line_done,
   input logic       rsp_unbalanced_quote,
   input logic       rsp_last
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> empty && !full)
      else $error("queue not empty after reset");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_line_done |-> rsp_last)
      else $error("line end result is not the last of its item");

   a_marker_blank: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_line_done |->
         rsp_out_char == 8'h00 && !rsp_ends_token && !rsp_operator_token)
      else $error("line end result carries a byte");

   a_unbal_with_done: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_unbalanced_quote |-> rsp_line_done)
      else $error("quote fault flagged before the end of the line");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_out_char) && $stable(rsp_last))
      else $error("waiting result changed under a stall");

endmodule

bind quote_aware_shell_tokenizer_core qast_checker u_qast_checker (
   .clock                (clock),
   .reset                (reset),
   .full                 (full),
   .empty                (empty),
   .pop                  (pop),
   .rsp_out_char         (rsp_out_char),
   .rsp_ends_token       (rsp_ends_token),
   .rsp_operator_token   (rsp_operator_token),
   .rsp_line_done        (rsp_line_done),
   .rsp_unbalanced_quote (rsp_unbalanced_quote),
   .rsp_last             (rsp_last)
);
